// ===== design/array_table_insert_remove_sort_top_macros.svh =====
// Assertion macros for the array table block.
// Used by the sequencer module; expects signals clk and rst_n in scope.
`ifndef ARRAY_TABLE_INSERT_REMOVE_SORT_TOP_MACROS_SVH
`define ARRAY_TABLE_INSERT_REMOVE_SORT_TOP_MACROS_SVH

// Check that expr holds in the same cycle as cond.
`define ATIS_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that expr holds in the cycle after cond.
`define ATIS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== design/atis_pkg.sv =====
// Shared types and constants for the array table block.
// No dependencies; imported by every module of the block.
package atis_pkg;

    // Field widths of the command and response transfers
    localparam int OP_BITS   = 3;
    localparam int POS_BITS  = 9;
    localparam int DATA_BITS = 32;
    localparam int CNT_BITS  = 9;
    localparam int ST_BITS   = 2;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_SORT   = 3'd4
    } op_t;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_READ,
        S_SORT
    } state_t;

    // Work still in flight behind the registered memory read
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_SHIFT,
        PEND_LOAD,
        PEND_CMP
    } pend_t;

    // Source of the memory write data
    typedef enum logic [1:0] {
        WSEL_RDATA,
        WSEL_HELD,
        WSEL_VALUE
    } wsel_t;

    // Control from the sequencer to the store
    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        wsel_t wr_sel;
        logic  held_load;
        logic  cmp_en;
    } store_ctl_t;

endpackage

// ===== design/atis_store.sv =====
// Entry memory with registered read, held word and signed compare unit.
// Depends on atis_pkg for the control struct.
module atis_store
    import atis_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                         clk,
    input  store_ctl_t                   ctl,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [WORD_BITS-1:0]         wr_value,
    output logic [WORD_BITS-1:0]         rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [WORD_BITS-1:0] mem_reg [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] held_reg;
    logic [WORD_BITS-1:0] held_next;
    logic [WORD_BITS-1:0] wr_data;
    logic                 greater;
    logic                 wr_fire;
    logic                 swap;

    // Signed compare of the held word against the last word read
    assign greater = $signed(held_reg) > $signed(rdata_reg);
    assign swap    = ctl.cmp_en & greater;
    assign wr_fire = ctl.wr_en | swap;

    // Select write data
    always_comb
    begin
        case (ctl.wr_sel)
            WSEL_RDATA: wr_data = rdata_reg;
            WSEL_HELD:  wr_data = held_reg;
            WSEL_VALUE: wr_data = wr_value;
            default:    wr_data = wr_value;
        endcase
    end

    // Take the read word into the held register on load or swap
    assign held_next = (ctl.held_load | swap) ? rdata_reg : held_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_addr[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[rd_addr[AW-1:0]];
        end
        held_reg <= held_next;
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/atis_seq.sv =====
// Command sequencer: range checks, live count, shift and sort stepping.
// Depends on atis_pkg and the assertion macros header.
`include "array_table_insert_remove_sort_top_macros.svh"

module atis_seq
    import atis_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [OP_BITS-1:0]           opcode,
    input  logic [POS_BITS-1:0]          position,
    input  logic signed [DATA_BITS-1:0]  item_value,
    output logic                         idle,
    output logic                         done,
    output logic [DATA_BITS-1:0]         rsp_read,
    output logic [CNT_BITS-1:0]          rsp_count,
    output status_t                      rsp_status,
    output store_ctl_t                   ctl,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic [WORD_BITS-1:0]         wr_value,
    input  logic [WORD_BITS-1:0]         rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    state_t          state_reg, state_next;
    pend_t           pend_reg, pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [WORD_BITS-1:0] val_reg, val_next;

    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic [PW-1:0]   cnt_fit;
    logic [63:0]     in_ext;
    logic [63:0]     rd_ext;
    logic [WORD_BITS-1:0] in_word;
    logic [CW-1:0]   km1;
    logic [CW:0]     kp1;
    logic [CW:0]     ip1;
    logic [CW:0]     ip2;
    logic [CW:0]     cnt1;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign in_ext  = {32'b0, item_value};
    assign in_word = in_ext[WORD_BITS-1:0];
    assign km1     = k_reg - 1'b1;
    assign kp1     = {1'b0, k_reg} + 1'b1;
    assign ip1     = {1'b0, i_reg} + 1'b1;
    assign ip2     = ip1 + 1'b1;
    assign cnt1    = {1'b0, count_reg};

    // Zero-extend the read word before fitting it to the response width
    always_comb
    begin
        rd_ext = '0;
        rd_ext[WORD_BITS-1:0] = rdata;
    end

    assign cnt_fit   = PW'(count_next);
    assign rsp_count = cnt_fit[CNT_BITS-1:0];
    assign idle      = (state_reg == S_IDLE);
    assign wr_value  = (state_reg == S_IDLE) ? in_word : val_reg;

    // Next state, store control and response
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = PEND_NONE;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        ctl            = '0;
        ctl.wr_sel     = WSEL_RDATA;
        rd_addr        = '0;
        wr_addr        = '0;
        done           = 1'b0;
        rsp_read       = '0;
        rsp_status     = ST_OK;

        // Retire the word read in the previous cycle
        case (pend_reg)
            PEND_SHIFT:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WSEL_RDATA;
                wr_addr    = pend_addr_reg;
            end
            PEND_LOAD:
            begin
                ctl.held_load = 1'b1;
            end
            PEND_CMP:
            begin
                ctl.cmp_en = 1'b1;
                ctl.wr_sel = WSEL_HELD;
                wr_addr    = pend_addr_reg;
            end
            default:
            begin
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(opcode))
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                done       = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else if (count_reg == CW'(DEPTH))
                            begin
                                done       = 1'b1;
                                rsp_status = ST_FULL;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                pos_next   = pos_ext[CW-1:0];
                                val_next   = in_word;
                                state_next = S_INS;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                done       = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else
                            begin
                                k_next     = pos_ext[CW-1:0];
                                state_next = S_REM;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                done       = 1'b1;
                                rsp_status = ST_RANGE;
                            end
                            else
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = pos_ext[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        OP_WRITE:
                        begin
                            done = 1'b1;
                            if (pos_ext >= cnt_ext)
                            begin
                                rsp_status = ST_RANGE;
                            end
                            else
                            begin
                                ctl.wr_en  = 1'b1;
                                ctl.wr_sel = WSEL_VALUE;
                                wr_addr    = pos_ext[AW-1:0];
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = '0;
                                pend_next  = PEND_LOAD;
                                i_next     = '0;
                                k_next     = CW'(1);
                                state_next = S_SORT;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            // Move entries up one a cycle, then place the new word
            S_INS:
            begin
                if (k_reg > pos_reg)
                begin
                    ctl.rd_en      = 1'b1;
                    rd_addr        = km1[AW-1:0];
                    pend_next      = PEND_SHIFT;
                    pend_addr_next = k_reg[AW-1:0];
                    k_next         = km1;
                end
                else if (pend_reg == PEND_NONE)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WSEL_VALUE;
                    wr_addr    = pos_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Move entries down one a cycle, then drop the last one
            S_REM:
            begin
                if (kp1 < cnt1)
                begin
                    ctl.rd_en      = 1'b1;
                    rd_addr        = kp1[AW-1:0];
                    pend_next      = PEND_SHIFT;
                    pend_addr_next = k_reg[AW-1:0];
                    k_next         = kp1[CW-1:0];
                end
                else if (pend_reg == PEND_NONE)
                begin
                    count_next = count_reg - 1'b1;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                rsp_read   = rd_ext[DATA_BITS-1:0];
                done       = 1'b1;
                state_next = S_IDLE;
            end

            // Compare the held word of slot i against each later slot
            S_SORT:
            begin
                if (k_reg < count_reg)
                begin
                    ctl.rd_en      = 1'b1;
                    rd_addr        = k_reg[AW-1:0];
                    pend_next      = PEND_CMP;
                    pend_addr_next = k_reg[AW-1:0];
                    k_next         = k_reg + 1'b1;
                end
                else if (pend_reg == PEND_NONE)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WSEL_HELD;
                    wr_addr    = i_reg[AW-1:0];
                    if (ip2 < cnt1)
                    begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = ip1[AW-1:0];
                        pend_next = PEND_LOAD;
                        i_next    = ip1[CW-1:0];
                        k_next    = ip2[CW-1:0];
                    end
                    else
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= PEND_NONE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

    // Indexes and command payload
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
    end

    `ATIS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "live count above depth")
    `ATIS_ASSERT_NOW(a_idle_drained, state_reg == S_IDLE, pend_reg == PEND_NONE, "pending work in idle")
    `ATIS_ASSERT_NOW(a_full_status, done && rsp_status == ST_FULL, count_reg == CW'(DEPTH), "full flagged below depth")
    `ATIS_ASSERT_NEXT(a_done_idle, done, state_reg == S_IDLE, "sequencer busy after result")

endmodule

// ===== design/array_table_insert_remove_sort_top.sv =====
// Array table: one command at a time; a command is busy from its accepting cycle to its last one.
// Rejects, write, ignored opcodes and sort of under two entries end in the accepting cycle; read
// returns the registered memory read; insert at p shifts entries from p up, then writes the word;
// remove shifts later entries down; sort uses one memory read port and one compare unit per step.
// The result is valid the cycle after the last busy one; input stalls while it is held off.
// Reset clears the live count and control state; entries stay undefined until written.
module array_table_insert_remove_sort_top
    import atis_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [OP_BITS-1:0]           opcode,
    input  logic [POS_BITS-1:0]          position,
    input  logic signed [DATA_BITS-1:0]  item_value,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic signed [DATA_BITS-1:0]  read_value,
    output logic [CNT_BITS-1:0]          entry_count,
    output logic [ST_BITS-1:0]           status
);

    localparam int AW = $clog2(DEPTH);

    logic                   start;
    logic                   seq_idle;
    logic                   seq_done;
    logic [DATA_BITS-1:0]   seq_read;
    logic [CNT_BITS-1:0]    seq_count;
    status_t                seq_status;
    store_ctl_t             store_ctl;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_value;
    logic [WORD_BITS-1:0]   rdata;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [DATA_BITS-1:0]   read_value_reg, read_value_next;
    logic [CNT_BITS-1:0]    entry_count_reg, entry_count_next;
    status_t                status_reg, status_next;

    // Take a command when the sequencer is free and the response slot drains
    assign cmd_stall = !seq_idle || (rsp_valid_reg && rsp_stall);
    assign start     = cmd_valid && !cmd_stall;

    atis_seq #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .position   (position),
        .item_value (item_value),
        .idle       (seq_idle),
        .done       (seq_done),
        .rsp_read   (seq_read),
        .rsp_count  (seq_count),
        .rsp_status (seq_status),
        .ctl        (store_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_value   (wr_value),
        .rdata      (rdata)
    );

    atis_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .clk      (clk),
        .ctl      (store_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .rdata    (rdata)
    );

    // Load a finished result; drop it once the transfer completes
    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        read_value_next  = read_value_reg;
        entry_count_next = entry_count_reg;
        status_next      = status_reg;
        if (seq_done)
        begin
            rsp_valid_next   = 1'b1;
            read_value_next  = seq_read;
            entry_count_next = seq_count;
            status_next      = seq_status;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        read_value_reg  <= read_value_next;
        entry_count_reg <= entry_count_next;
        status_reg      <= status_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

endmodule
